FILE: sv/pnr_pkg.sv
// Package for the polynomial Newton root core: constants, status codes, command types.
// Used by all modules of the block; depends on nothing.
package pnr_pkg;

    localparam int DEF_MAX_COEFFS = 16;
    localparam int DEF_FRACTION_BITS = 16;

    localparam logic [1:0] ST_CONVERGED = 2'd0;
    localparam logic [1:0] ST_ZERO_DERIV = 2'd1;
    localparam logic [1:0] ST_LIMIT = 2'd2;

    localparam logic [1:0] CFG_DEGREE = 2'd0;
    localparam logic [1:0] CFG_TOL = 2'd1;
    localparam logic [1:0] CFG_LIMIT = 2'd2;

    typedef struct packed {
        logic load_x;
        logic clear_acc;
        logic horner_step;
        logic start_div;
        logic update_x;
    } pnr_cmd_t;

    typedef struct packed {
        logic f_small;
        logic fp_zero;
        logic div_done;
    } pnr_stat_t;

    function automatic logic [31:0] sat32(input logic signed [65:0] v);
        logic [31:0] r;
        if (v > 66'sh07FFFFFFF) r = 32'h7FFFFFFF;
        else if (v < -66'sh080000000) r = 32'h80000000;
        else r = v[31:0];
        return r;
    endfunction

endpackage

FILE: sv/pnr_datapath.sv
// Datapath of the polynomial Newton root core: coefficient store, Horner unit, divider.
// Depends on pnr_pkg; driven by pnr_ctrl through command signals.
module pnr_datapath #(
    parameter int MAX_COEFFS = pnr_pkg::DEF_MAX_COEFFS,
    parameter int FRACTION_BITS = pnr_pkg::DEF_FRACTION_BITS,
    localparam int IW = $clog2(MAX_COEFFS)
) (
    input  logic clk,
    input  logic rst_n,
    input  logic coef_we,
    input  logic [IW-1:0] coef_idx,
    input  logic [31:0] coef_data,
    input  logic [IW-1:0] rd_idx,
    input  logic [IW-1:0] rd_next,
    input  logic [31:0] guess,
    input  logic [30:0] tol,
    input  pnr_pkg::pnr_cmd_t cmd,
    output pnr_pkg::pnr_stat_t stat,
    output logic [31:0] x_out
);
    import pnr_pkg::*;

    localparam int DW = 32 + FRACTION_BITS;

    logic [31:0] store_reg [MAX_COEFFS];
    logic [MAX_COEFFS-1:0] vld_reg;
    logic [31:0] rd_data_reg;
    logic rd_vld_reg;
    logic [31:0] x_reg, f_reg, fp_reg;
    logic [31:0] coef_rd;
    logic signed [63:0] pf, pfp;
    logic [31:0] mf, mfp, dcoef;
    logic signed [65:0] sumf, sumfp;
    logic signed [32+IW:0] dprod;
    logic [DW-1:0] num_reg;
    logic [31:0] den_reg;
    logic [32:0] rem_reg;
    logic [DW-1:0] quo_reg;
    logic [6:0] cnt_reg;
    logic neg_reg, busy_reg, done_reg;
    logic [32:0] rem_sh, rem_sub;
    logic signed [DW:0] qs;
    logic [31:0] qsat;
    logic [32:0] af;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (coef_we)
        begin
            vld_reg[coef_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            store_reg[coef_idx] <= coef_data;
        end
        rd_data_reg <= store_reg[rd_next];
        rd_vld_reg <= vld_reg[rd_next];
    end

    assign coef_rd = rd_vld_reg ? rd_data_reg : 32'd0;

    function automatic logic [31:0] qmul(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p >>> FRACTION_BITS;
        return sat32(66'(s));
    endfunction

    assign pf = $signed(f_reg) * $signed(x_reg);
    assign pfp = $signed(fp_reg) * $signed(x_reg);
    assign mf = qmul(pf);
    assign mfp = qmul(pfp);
    assign dprod = $signed(coef_rd) * $signed({1'b0, rd_idx});
    assign dcoef = sat32(66'(dprod));
    assign sumf = 66'($signed(mf)) + 66'($signed(coef_rd));
    assign sumfp = 66'($signed(mfp)) + 66'($signed(dcoef));

    always_ff @(posedge clk)
    begin
        if (cmd.load_x)
        begin
            x_reg <= guess;
        end
        else if (cmd.update_x)
        begin
            x_reg <= sat32(66'($signed(x_reg)) - 66'($signed(qsat)));
        end
        if (cmd.clear_acc)
        begin
            f_reg <= '0;
            fp_reg <= '0;
        end
        else if (cmd.horner_step)
        begin
            f_reg <= sat32(sumf);
            if (rd_idx != '0)
            begin
                fp_reg <= sat32(sumfp);
            end
        end
    end

    assign rem_sh = {rem_reg[31:0], num_reg[DW-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (cmd.start_div)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg <= 7'(DW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 7'd1;
            done_reg <= cnt_reg == 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_reg <= 1'b0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_div)
        begin
            num_reg <= {(f_reg[31] ? 32'(-f_reg) : f_reg), {FRACTION_BITS{1'b0}}};
            den_reg <= fp_reg[31] ? 32'(-fp_reg) : fp_reg;
            neg_reg <= f_reg[31] ^ fp_reg[31];
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DW-2:0], 1'b0};
            if (!rem_sub[32])
            begin
                rem_reg <= rem_sub;
                quo_reg <= {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[DW-2:0], 1'b0};
            end
        end
    end

    assign qs = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign qsat = sat32(66'(qs));
    assign af = f_reg[31] ? 33'(-$signed({f_reg[31], f_reg})) : {1'b0, f_reg};

    assign stat.f_small = af < {2'b0, tol};
    assign stat.fp_zero = fp_reg == '0;
    assign stat.div_done = done_reg;
    assign x_out = x_reg;

`ifndef NO_ASSERTIONS
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != 7'd0) else $error("divider count empty while busy");
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_div |=> busy_reg) else $error("divider did not start");
    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> !busy_reg) else $error("divider did not finish");
`endif

endmodule

FILE: sv/pnr_ctrl.sv
// Controller of the polynomial Newton root core: sequences Horner passes and division.
// Depends on pnr_pkg; commands pnr_datapath.
module pnr_ctrl #(
    parameter int MAX_COEFFS = pnr_pkg::DEF_MAX_COEFFS,
    localparam int IW = $clog2(MAX_COEFFS)
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic [3:0] degree,
    input  logic [7:0] limit,
    input  logic out_free,
    input  pnr_pkg::pnr_stat_t stat,
    output pnr_pkg::pnr_cmd_t cmd,
    output logic [IW-1:0] rd_idx,
    output logic [IW-1:0] rd_next,
    output logic idle,
    output logic finish,
    output logic [1:0] fin_status,
    output logic [7:0] fin_iters
);
    import pnr_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EVAL = 5'b00010,
        S_TEST = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next, top;
    logic [7:0] it_reg, it_next;
    logic [1:0] st_reg, st_next;

    always_comb
    begin
        if (32'(degree) > MAX_COEFFS - 1) top = IW'(MAX_COEFFS - 1);
        else top = IW'(degree);
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        it_next = it_reg;
        st_next = st_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_x = 1'b1;
                    cmd.clear_acc = 1'b1;
                    idx_next = top;
                    it_next = '0;
                    if (limit == '0)
                    begin
                        st_next = ST_LIMIT;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_EVAL;
                    end
                end
            end
            S_EVAL:
            begin
                cmd.horner_step = 1'b1;
                if (idx_reg == '0) state_next = S_TEST;
                else idx_next = idx_reg - IW'(1);
            end
            S_TEST:
            begin
                if (stat.f_small)
                begin
                    st_next = ST_CONVERGED;
                    state_next = S_DONE;
                end
                else if (stat.fp_zero)
                begin
                    st_next = ST_ZERO_DERIV;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.start_div = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.update_x = 1'b1;
                    it_next = it_reg + 8'd1;
                    if (it_reg + 8'd1 == limit)
                    begin
                        st_next = ST_LIMIT;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_EVAL;
                        idx_next = top;
                    end
                end
            end
            S_DONE:
            begin
                cmd.clear_acc = 1'b1;
                if (out_free) state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (state_reg == S_DIV && stat.div_done) cmd.clear_acc = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg <= '0;
            it_reg <= '0;
            st_reg <= ST_CONVERGED;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            it_reg <= it_next;
            st_reg <= st_next;
        end
    end

    assign rd_idx = idx_reg;
    assign rd_next = idx_next;
    assign idle = state_reg == S_IDLE;
    assign finish = state_reg == S_DONE && out_free;
    assign fin_status = st_reg;
    assign fin_iters = it_reg;

`ifndef NO_ASSERTIONS
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
    a_iter: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EVAL |-> it_reg < limit) else $error("iteration past limit");
    a_fin: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> state_reg == S_IDLE) else $error("finish did not return to idle");
`endif

endmodule

FILE: sv/polynomial_newton_root_core.sv
// Polynomial Newton root core. A solve runs Newton passes, each a serial Horner walk over
// the coefficients followed by the bit-serial divider (one quotient bit per cycle).
// One item is processed at a time; the result waits in an output register.
// Reset (rst_n, asynchronous, active low) clears the coefficients via valid bits and
// sets degree 0, tolerance 66, iteration limit 100.
module polynomial_newton_root_core #(
    parameter int MAX_COEFFS = pnr_pkg::DEF_MAX_COEFFS,
    parameter int FRACTION_BITS = pnr_pkg::DEF_FRACTION_BITS
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [31:0] cfg_data,
    input  logic in_valid,
    output logic in_stall,
    input  logic kind,
    input  logic [3:0] coef_index,
    input  logic signed [31:0] coef_value,
    input  logic signed [31:0] start_guess,
    output logic out_valid,
    input  logic out_stall,
    output logic signed [31:0] root_value,
    output logic [1:0] status,
    output logic [7:0] iterations_used
);
    import pnr_pkg::*;

    localparam int IW = $clog2(MAX_COEFFS);

    logic [3:0] deg_reg;
    logic [30:0] tol_reg;
    logic [7:0] lim_reg;
    logic ovalid_reg;
    logic [31:0] root_reg;
    logic [1:0] status_reg;
    logic [7:0] iters_reg;
    logic idle, finish, accept, coef_we, out_free;
    logic [1:0] fin_status;
    logic [7:0] fin_iters;
    logic [IW-1:0] rd_idx;
    logic [IW-1:0] rd_next;
    logic [31:0] x_out;
    pnr_cmd_t cmd;
    pnr_stat_t stat;

    assign cfg_ready = 1'b1;
    assign in_stall = !idle;
    assign accept = in_valid && idle;
    assign coef_we = accept && !kind && 32'(coef_index) < MAX_COEFFS;
    assign out_free = !ovalid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deg_reg <= '0;
            tol_reg <= 31'd66;
            lim_reg <= 8'd100;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_DEGREE: deg_reg <= cfg_data[3:0];
                    CFG_TOL: tol_reg <= cfg_data[30:0];
                    CFG_LIMIT: lim_reg <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (finish) ovalid_reg <= 1'b1;
            else if (!out_stall) ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            root_reg <= x_out;
            status_reg <= fin_status;
            iters_reg <= fin_iters;
        end
    end

    pnr_ctrl #(.MAX_COEFFS(MAX_COEFFS)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(accept && kind), .degree(deg_reg),
        .limit(lim_reg), .out_free(out_free), .stat(stat), .cmd(cmd),
        .rd_idx(rd_idx), .rd_next(rd_next), .idle(idle), .finish(finish),
        .fin_status(fin_status), .fin_iters(fin_iters)
    );

    pnr_datapath #(.MAX_COEFFS(MAX_COEFFS), .FRACTION_BITS(FRACTION_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .coef_we(coef_we), .coef_idx(IW'(coef_index)),
        .coef_data(coef_value), .rd_idx(rd_idx), .rd_next(rd_next),
        .guess(start_guess), .tol(tol_reg),
        .cmd(cmd), .stat(stat), .x_out(x_out)
    );

    assign out_valid = ovalid_reg;
    assign root_value = root_reg;
    assign status = status_reg;
    assign iterations_used = iters_reg;

`ifndef NO_ASSERTIONS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(root_value))
        else $error("stalled item changed");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && kind |=> in_stall) else $error("accepted solve while busy");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3) else $error("bad status code");
`endif

endmodule

FILE: tb/tb.sv
// Testbench for polynomial_newton_root_core: coefficient loads, register writes and root
// solves, checked against a Q16.16 Newton iteration predictor. Depends on pnr_pkg and the core.
`timescale 1ns / 100ps

module tb;
    import pnr_pkg::*;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_SOLVE = 1'b1;
    localparam int STALL_LIMIT = 60000;

    typedef enum int { OP_LOAD, OP_SOLVE, OP_CFG } op_e;

    typedef struct {
        op_e op;
        logic [3:0] idx;
        int val;
        bit typed;
        int e_root;
        logic [1:0] e_status;
        logic [7:0] e_iters;
    } plan_row_t;

    typedef struct {
        int root;
        logic [1:0] status;
        logic [7:0] iters;
    } solution_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic kind;
    logic [3:0] coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] start_guess;
    logic out_valid;
    logic out_stall;
    logic signed [31:0] root_value;
    logic [1:0] status;
    logic [7:0] iterations_used;

    int coef_mem [16];
    logic [3:0] degree_q;
    logic [30:0] tol_q;
    logic [7:0] limit_q;
    solution_t pending_roots [$];
    plan_row_t plan [$];
    int mismatches;
    int quiet_cycles;
    bit no_idle;

    polynomial_newton_root_core i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .coef_index(coef_index),
        .coef_value(coef_value),
        .start_guess(start_guess),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .root_value(root_value),
        .status(status),
        .iterations_used(iterations_used)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int clamp32(input longint v);
        if (v > longint'(32'sh7FFFFFFF))
        begin
            return 32'sh7FFFFFFF;
        end
        if (v < -longint'(64'sh80000000))
        begin
            return 32'sh80000000;
        end
        return int'(v);
    endfunction

    function automatic int fx_mul(input int a, input int b);
        longint p;
        p = longint'(a) * longint'(b);
        return clamp32(p >>> 16);
    endfunction

    function automatic int poly_at(input int x, input bit slope);
        int acc;
        int term;
        acc = 0;
        for (int i = 15; i >= 0; i--)
        begin
            if (i <= degree_q && (!slope || i >= 1))
            begin
                term = slope ? clamp32(longint'(coef_mem[i]) * i) : coef_mem[i];
                acc = clamp32(longint'(fx_mul(acc, x)) + longint'(term));
            end
        end
        return acc;
    endfunction

    function automatic solution_t newton_solve(input int guess);
        solution_t s;
        int x;
        int f;
        int fp;
        longint af;
        longint q;
        int n;
        x = guess;
        s.status = ST_LIMIT;
        for (n = 0; n < limit_q; n++)
        begin
            f = poly_at(x, 1'b0);
            fp = poly_at(x, 1'b1);
            af = (f < 0) ? -longint'(f) : longint'(f);
            if (af < longint'(tol_q))
            begin
                s.status = ST_CONVERGED;
                break;
            end
            if (fp == 0)
            begin
                s.status = ST_ZERO_DERIV;
                break;
            end
            q = (longint'(f) * 65536) / longint'(fp);
            x = clamp32(longint'(x) - longint'(clamp32(q)));
        end
        s.root = x;
        s.iters = n[7:0];
        return s;
    endfunction

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_roots.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
        begin
            @(posedge clk);
        end
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_DEGREE: degree_q = data[3:0];
            CFG_TOL: tol_q = data[30:0];
            CFG_LIMIT: limit_q = data[7:0];
            default: ;
        endcase
    endtask

    task automatic send_item(input logic k, input logic [3:0] idx, input int val,
                             input bit typed, input solution_t typed_sol);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        coef_index <= idx;
        coef_value <= (k == KIND_LOAD) ? val : $urandom;
        start_guess <= (k == KIND_SOLVE) ? val : $urandom;
        do
        begin
            @(posedge clk);
        end
        while (in_stall !== 1'b0);
        if (k == KIND_LOAD)
        begin
            coef_mem[idx] = val;
        end
        else
        begin
            pending_roots.push_back(typed ? typed_sol : newton_solve(val));
        end
    endtask

    function automatic int rand_q();
        if ($urandom_range(0, 3) == 0)
        begin
            return $urandom;
        end
        return int'($urandom_range(0, 32'h60000)) - 32'h30000;
    endfunction

    initial
    begin
        solution_t s;
        solution_t none;
        int tol_pick;
        none = '{0, ST_CONVERGED, 8'd0};
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        kind = KIND_LOAD;
        coef_index = '0;
        coef_value = '0;
        start_guess = '0;
        for (int i = 0; i < 16; i++)
        begin
            coef_mem[i] = 0;
        end
        degree_q = 4'd0;
        tol_q = 31'd66;
        limit_q = 8'd100;
        no_idle = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        plan = '{
            '{OP_SOLVE, 4'd0, 0, 1, 0, ST_CONVERGED, 8'd0},
            '{OP_SOLVE, 4'd0, 32'h80000000, 1, 32'h80000000, ST_CONVERGED, 8'd0},
            '{OP_LOAD, 4'd0, 32'h7FFFFFFF, 0, 0, ST_CONVERGED, 8'd0},
            '{OP_SOLVE, 4'd0, 5, 1, 5, ST_ZERO_DERIV, 8'd0},
            '{OP_LOAD, 4'd0, 32'h80000000, 0, 0, ST_CONVERGED, 8'd0},
            '{OP_SOLVE, 4'd0, -7, 1, -7, ST_ZERO_DERIV, 8'd0},
            '{OP_LOAD, 4'd0, 0, 0, 0, ST_CONVERGED, 8'd0},
            '{OP_CFG, CFG_TOL, 0, 0, 0, ST_CONVERGED, 8'd0},
            '{OP_SOLVE, 4'd0, 3, 1, 3, ST_ZERO_DERIV, 8'd0},
            '{OP_CFG, CFG_TOL, 32'h7FFFFFFF, 0, 0, ST_CONVERGED, 8'd0},
            '{OP_LOAD, 4'd0, 32'h80000000, 0, 0, ST_CONVERGED, 8'd0},
            '{OP_SOLVE, 4'd0, 9, 1, 9, ST_ZERO_DERIV, 8'd0},
            '{OP_CFG, CFG_TOL, 66, 0, 0, ST_CONVERGED, 8'd0},
            '{OP_CFG, CFG_DEGREE, 1, 0, 0, ST_CONVERGED, 8'd0},
            '{OP_LOAD, 4'd1, 32'h10000, 0, 0, ST_CONVERGED, 8'd0},
            '{OP_LOAD, 4'd0, 32'hFFFE0000, 0, 0, ST_CONVERGED, 8'd0},
            '{OP_SOLVE, 4'd0, 0, 0, 0, ST_CONVERGED, 8'd0},
            '{OP_SOLVE, 4'd0, 32'h80000000, 0, 0, ST_CONVERGED, 8'd0},
            '{OP_SOLVE, 4'd0, 32'h7FFFFFFF, 0, 0, ST_CONVERGED, 8'd0},
            '{OP_CFG, CFG_DEGREE, 15, 0, 0, ST_CONVERGED, 8'd0},
            '{OP_LOAD, 4'd15, 32'h7FFFFFFF, 0, 0, ST_CONVERGED, 8'd0},
            '{OP_SOLVE, 4'd0, 32'h10000, 0, 0, ST_CONVERGED, 8'd0},
            '{OP_CFG, CFG_LIMIT, 0, 0, 0, ST_CONVERGED, 8'd0},
            '{OP_SOLVE, 4'd0, 32'h1234, 1, 32'h1234, ST_LIMIT, 8'd0},
            '{OP_CFG, CFG_LIMIT, 255, 0, 0, ST_CONVERGED, 8'd0},
            '{OP_CFG, CFG_DEGREE, 2, 0, 0, ST_CONVERGED, 8'd0},
            '{OP_LOAD, 4'd15, 0, 0, 0, ST_CONVERGED, 8'd0},
            '{OP_LOAD, 4'd2, 32'h10000, 0, 0, ST_CONVERGED, 8'd0},
            '{OP_LOAD, 4'd1, 0, 0, 0, ST_CONVERGED, 8'd0},
            '{OP_LOAD, 4'd0, 32'h20000, 0, 0, ST_CONVERGED, 8'd0},
            '{OP_SOLVE, 4'd0, 32'h8000, 0, 0, ST_CONVERGED, 8'd0}
        };
        foreach (plan[r])
        begin
            s = '{plan[r].e_root, plan[r].e_status, plan[r].e_iters};
            case (plan[r].op)
                OP_CFG: write_reg(plan[r].idx[1:0], plan[r].val);
                OP_LOAD: send_item(KIND_LOAD, plan[r].idx, plan[r].val, 1'b0, none);
                default: send_item(KIND_SOLVE, plan[r].idx, plan[r].val, plan[r].typed, s);
            endcase
        end

        for (int ph = 0; ph < 10; ph++)
        begin
            write_reg(CFG_DEGREE, ($urandom_range(0, 3) == 0) ? 15 : $urandom_range(0, 4));
            tol_pick = $urandom_range(0, 5);
            write_reg(CFG_TOL, (tol_pick == 0) ? 0 : (tol_pick == 1) ? 32'h7FFFFFFF :
                      (tol_pick == 2) ? $urandom : $urandom_range(1, 2000));
            write_reg(CFG_LIMIT, (ph == 5) ? 255 : $urandom_range(0, 16));
            no_idle = (ph % 4 == 1);
            for (int n = 0; n < 24; n++)
            begin
                if (ph == 3 && n % 6 == 0)
                begin
                    drain();
                end
                if ($urandom_range(0, 1) == 0)
                begin
                    send_item(KIND_LOAD, $urandom_range(0, 15), rand_q(), 1'b0, none);
                end
                else
                begin
                    send_item(KIND_SOLVE, $urandom, rand_q(), 1'b0, none);
                end
            end
        end
        no_idle = 1'b0;
        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

    initial
    begin
        solution_t e;
        int gap;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, 16);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while (out_valid !== 1'b1 || out_stall !== 1'b0);
            if (pending_roots.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Unexpected result: root %h status %0d iterations %0d",
                             root_value, status, iterations_used);
                end
            end
            else
            begin
                e = pending_roots.pop_front();
                if (root_value !== e.root || status !== e.status
                    || iterations_used !== e.iters)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("Mismatch: expected root %h status %0d iterations %0d, got root %h status %0d iterations %0d",
                                 e.root, e.status, e.iters, root_value, status,
                                 iterations_used);
                    end
                end
            end
        end
    end

    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)
                || (cfg_valid && cfg_ready === 1'b1))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

endmodule
